/* hw/rtl/stls_pkg.sv */
// ----------------------------------------------------------------------------
// stls_pkg
// Shared types and constants for the source text line statistics block.
// ----------------------------------------------------------------------------
package stls_pkg;

    localparam int unsigned NUM_STATS  = 12;
    localparam int unsigned STAT_W     = 32;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned PREFIX_MAX = 8;

    // Counter slots, in output order (lowest tdata bits first)
    typedef enum logic [3:0] {
        C_LINES   = 4'd0,
        C_BLANK   = 4'd1,
        C_COMMENT = 4'd2,
        C_CODE    = 4'd3,
        C_WORDS   = 4'd4,
        C_CHARS   = 4'd5,
        C_INCL    = 4'd6,
        C_CLASS   = 4'd7,
        C_STRUCT  = 4'd8,
        C_ENUM    = 4'd9,
        C_FUNC    = 4'd10,
        C_LONGEST = 4'd11
    } stat_idx_t;

    // Per-line found flags
    localparam int unsigned F_OPEN   = 0;
    localparam int unsigned F_CLOSE  = 1;
    localparam int unsigned F_BRACE  = 2;
    localparam int unsigned F_ENDC   = 3;
    localparam int unsigned F_CLASS  = 4;
    localparam int unsigned F_STRUCT = 5;
    localparam int unsigned F_ENUM   = 6;
    localparam int unsigned FLAG_W   = 7;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";
    localparam logic [7:0] CH_BRACE = "{";

    // Tail patterns: newest byte in the low bits
    localparam logic [15:0] T_ENDC   = "*/";
    localparam logic [47:0] T_CLASS  = "class ";
    localparam logic [55:0] T_STRUCT = "struct ";
    localparam logic [39:0] T_ENUM   = "enum ";

    // Turn a right-aligned string of n chars into prefix order (char 0 lowest)
    function automatic logic [63:0] to_prefix(input logic [63:0] s, input int unsigned n);
        logic [63:0] r;
        for (int j = 0; j < 8; j++) begin
            r[8*(7-j) +: 8] = s[8*j +: 8];
        end
        return r >> (8 * (8 - n));
    endfunction

    function automatic logic [63:0] prefix_mask(input int unsigned n);
        return ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * n));
    endfunction

    localparam logic [63:0] P_LINE_CMT  = to_prefix(64'("//"), 2);
    localparam logic [63:0] P_BLOCK_CMT = to_prefix(64'("/*"), 2);
    localparam logic [63:0] P_INCLUDE   = to_prefix(64'("#include"), 8);
    localparam logic [63:0] P_IF        = to_prefix(64'("if"), 2);
    localparam logic [63:0] P_FOR       = to_prefix(64'("for"), 3);
    localparam logic [63:0] P_WHILE     = to_prefix(64'("while"), 5);
    localparam logic [63:0] P_SWITCH    = to_prefix(64'("switch"), 6);
    localparam logic [63:0] P_CATCH     = to_prefix(64'("catch"), 5);

    localparam logic [63:0] M_2 = prefix_mask(2);
    localparam logic [63:0] M_3 = prefix_mask(3);
    localparam logic [63:0] M_5 = prefix_mask(5);
    localparam logic [63:0] M_6 = prefix_mask(6);
    localparam logic [63:0] M_8 = prefix_mask(8);

    // Pattern bytes are all nonzero and unfilled prefix bytes are zero,
    // so a match implies the prefix holds enough bytes.
    function automatic logic prefix_is(input logic [63:0] pfx, input logic [63:0] pat,
                                       input logic [63:0] mask);
        return ((pfx ^ pat) & mask) == 64'd0;
    endfunction

    // Counter updates produced by one transaction
    typedef struct packed {
        logic              char_inc;
        logic              word_inc;
        logic              line_end;
        logic              blank;
        logic              comment;
        logic              code;
        logic              incl;
        logic              cls;
        logic              strct;
        logic              enm;
        logic              func;
        logic [LEN_W-1:0]  line_len;
        logic              file_end;
    } line_event_t;

endpackage

/* hw/rtl/stls_line_scan.sv */
// ----------------------------------------------------------------------------
// stls_line_scan
// Per-line state: word tracking, trimmed prefix, match window, found flags,
// line length and block-comment state. Classifies each finished line.
// ----------------------------------------------------------------------------
module stls_line_scan
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               byte_value,
    input  logic                     byte_present,
    input  logic                     end_of_file,
    output stls_pkg::line_event_t    ev
);

    logic                           in_block_reg,  in_block_next;
    logic                           in_word_reg,   in_word_next;
    logic                           has_bytes_reg, has_bytes_next;
    logic                           nonspace_reg,  nonspace_next;
    logic [63:0]                    prefix_reg,    prefix_next;
    logic [3:0]                     fill_reg,      fill_next;
    logic [47:0]                    window_reg,    window_next;
    logic [stls_pkg::FLAG_W-1:0]    flags_reg,     flags_next;
    logic [stls_pkg::LEN_W-1:0]     len_reg,       len_next;

    // state after the byte, before any line end
    logic                           take;
    logic                           is_sp;
    logic                           a_in_word;
    logic                           a_has_bytes;
    logic                           a_nonspace;
    logic [63:0]                    a_prefix;
    logic [3:0]                     a_fill;
    logic [55:0]                    win_w;
    logic [stls_pkg::FLAG_W-1:0]    a_flags;
    logic [stls_pkg::LEN_W-1:0]     a_len;
    logic                           fin;
    logic                           pfx_line, pfx_block, pfx_ctrl;
    logic                           line_cmt;
    logic                           is_code;
    logic                           in_block_fin;

    always_comb
    begin
        take  = byte_present && (byte_value != stls_pkg::CH_NL);
        is_sp = (byte_value == stls_pkg::CH_SPACE) || (byte_value == stls_pkg::CH_TAB) ||
                (byte_value == stls_pkg::CH_VT) || (byte_value == stls_pkg::CH_FF) ||
                (byte_value == stls_pkg::CH_CR);

        a_has_bytes = has_bytes_reg || take;
        a_in_word   = take ? !is_sp : in_word_reg;
        a_nonspace  = nonspace_reg || (take && !is_sp);
        a_len       = (take && (len_reg != '1)) ? len_reg + 1'b1 : len_reg;

        a_prefix = prefix_reg;
        a_fill   = fill_reg;
        if (take && a_nonspace && (fill_reg < 4'(stls_pkg::PREFIX_MAX)))
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (fill_reg == 4'(i))
                begin
                    a_prefix[8*i +: 8] = byte_value;
                end
            end
            a_fill = fill_reg + 4'd1;
        end

        win_w   = {window_reg, byte_value};
        a_flags = flags_reg;
        if (take)
        begin
            if (byte_value == stls_pkg::CH_OPEN)  a_flags[stls_pkg::F_OPEN]  = 1'b1;
            if (byte_value == stls_pkg::CH_CLOSE) a_flags[stls_pkg::F_CLOSE] = 1'b1;
            if (byte_value == stls_pkg::CH_BRACE) a_flags[stls_pkg::F_BRACE] = 1'b1;
            if (win_w[15:0] == stls_pkg::T_ENDC)   a_flags[stls_pkg::F_ENDC]   = 1'b1;
            if (win_w[47:0] == stls_pkg::T_CLASS)  a_flags[stls_pkg::F_CLASS]  = 1'b1;
            if (win_w[55:0] == stls_pkg::T_STRUCT) a_flags[stls_pkg::F_STRUCT] = 1'b1;
            if (win_w[39:0] == stls_pkg::T_ENUM)   a_flags[stls_pkg::F_ENUM]   = 1'b1;
        end

        // a newline byte or an end of file with a pending line
        fin = (byte_present && (byte_value == stls_pkg::CH_NL)) ||
              (end_of_file && a_has_bytes);

        pfx_line  = stls_pkg::prefix_is(a_prefix, stls_pkg::P_LINE_CMT, stls_pkg::M_2);
        pfx_block = stls_pkg::prefix_is(a_prefix, stls_pkg::P_BLOCK_CMT, stls_pkg::M_2);
        pfx_ctrl  = stls_pkg::prefix_is(a_prefix, stls_pkg::P_IF, stls_pkg::M_2) ||
                    stls_pkg::prefix_is(a_prefix, stls_pkg::P_FOR, stls_pkg::M_3) ||
                    stls_pkg::prefix_is(a_prefix, stls_pkg::P_WHILE, stls_pkg::M_5) ||
                    stls_pkg::prefix_is(a_prefix, stls_pkg::P_SWITCH, stls_pkg::M_6) ||
                    stls_pkg::prefix_is(a_prefix, stls_pkg::P_CATCH, stls_pkg::M_5);

        line_cmt = a_nonspace && (in_block_reg || pfx_line || pfx_block);
        is_code  = a_nonspace && !line_cmt;

        in_block_fin = in_block_reg;
        if (a_nonspace)
        begin
            if (in_block_reg)
            begin
                if (a_flags[stls_pkg::F_ENDC]) in_block_fin = 1'b0;
            end
            else if (!pfx_line && pfx_block && !a_flags[stls_pkg::F_ENDC])
            begin
                in_block_fin = 1'b1;
            end
        end

        ev.char_inc = take;
        ev.word_inc = take && !is_sp && !in_word_reg;
        ev.line_end = fin;
        ev.blank    = fin && !a_nonspace;
        ev.comment  = fin && line_cmt;
        ev.code     = fin && is_code;
        ev.incl     = fin && is_code &&
                      stls_pkg::prefix_is(a_prefix, stls_pkg::P_INCLUDE, stls_pkg::M_8);
        ev.cls      = fin && is_code && a_flags[stls_pkg::F_CLASS];
        ev.strct    = fin && is_code && a_flags[stls_pkg::F_STRUCT];
        ev.enm      = fin && is_code && a_flags[stls_pkg::F_ENUM];
        ev.func     = fin && is_code && a_flags[stls_pkg::F_OPEN] &&
                      a_flags[stls_pkg::F_CLOSE] && a_flags[stls_pkg::F_BRACE] && !pfx_ctrl;
        ev.line_len = a_len;
        ev.file_end = end_of_file;

        // next state
        in_block_next  = fin ? in_block_fin : in_block_reg;
        in_word_next   = a_in_word;
        has_bytes_next = a_has_bytes;
        nonspace_next  = a_nonspace;
        prefix_next    = a_prefix;
        fill_next      = a_fill;
        window_next    = take ? win_w[47:0] : window_reg;
        flags_next     = a_flags;
        len_next       = a_len;
        if (fin || end_of_file)
        begin
            in_word_next   = 1'b0;
            has_bytes_next = 1'b0;
            nonspace_next  = 1'b0;
            prefix_next    = '0;
            fill_next      = '0;
            window_next    = '0;
            flags_next     = '0;
            len_next       = '0;
        end
        if (end_of_file)
        begin
            in_block_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg  <= 1'b0;
            in_word_reg   <= 1'b0;
            has_bytes_reg <= 1'b0;
            nonspace_reg  <= 1'b0;
            prefix_reg    <= '0;
            fill_reg      <= '0;
            window_reg    <= '0;
            flags_reg     <= '0;
            len_reg       <= '0;
        end
        else if (step)
        begin
            in_block_reg  <= in_block_next;
            in_word_reg   <= in_word_next;
            has_bytes_reg <= has_bytes_next;
            nonspace_reg  <= nonspace_next;
            prefix_reg    <= prefix_next;
            fill_reg      <= fill_next;
            window_reg    <= window_next;
            flags_reg     <= flags_next;
            len_reg       <= len_next;
        end
    end

endmodule

/* hw/rtl/stls_stat_bank.sv */
// ----------------------------------------------------------------------------
// stls_stat_bank
// Twelve saturating file counters. Presents the updated totals and clears
// them at end of file.
// ----------------------------------------------------------------------------
module stls_stat_bank #(
    parameter int unsigned COUNT_BITS = 32
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           step,
    input  stls_pkg::line_event_t                          ev,
    output logic [stls_pkg::NUM_STATS*stls_pkg::STAT_W-1:0] totals
);

    localparam int unsigned CMP_W = (COUNT_BITS > stls_pkg::LEN_W) ? COUNT_BITS
                                                                   : stls_pkg::LEN_W;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({COUNT_BITS{1'b1}});

    logic [COUNT_BITS-1:0] cnt_reg  [stls_pkg::NUM_STATS];
    logic [COUNT_BITS-1:0] cnt_next [stls_pkg::NUM_STATS];
    logic [stls_pkg::NUM_STATS-1:0] inc;
    logic [CMP_W-1:0]      len_wide;
    logic [COUNT_BITS-1:0] len_clip;

    always_comb
    begin
        inc = '0;
        inc[stls_pkg::C_LINES]   = ev.line_end;
        inc[stls_pkg::C_BLANK]   = ev.blank;
        inc[stls_pkg::C_COMMENT] = ev.comment;
        inc[stls_pkg::C_CODE]    = ev.code;
        inc[stls_pkg::C_WORDS]   = ev.word_inc;
        inc[stls_pkg::C_CHARS]   = ev.char_inc;
        inc[stls_pkg::C_INCL]    = ev.incl;
        inc[stls_pkg::C_CLASS]   = ev.cls;
        inc[stls_pkg::C_STRUCT]  = ev.strct;
        inc[stls_pkg::C_ENUM]    = ev.enm;
        inc[stls_pkg::C_FUNC]    = ev.func;

        for (int k = 0; k < stls_pkg::NUM_STATS; k++)
        begin
            cnt_next[k] = (inc[k] && (cnt_reg[k] != '1)) ? cnt_reg[k] + 1'b1 : cnt_reg[k];
        end

        // longest line: clip the length to the counter range, keep the max
        len_wide = CMP_W'(ev.line_len);
        len_clip = (len_wide > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(len_wide);
        cnt_next[stls_pkg::C_LONGEST] =
            (ev.line_end && (len_clip > cnt_reg[stls_pkg::C_LONGEST])) ?
            len_clip : cnt_reg[stls_pkg::C_LONGEST];

        for (int k = 0; k < stls_pkg::NUM_STATS; k++)
        begin
            totals[stls_pkg::STAT_W*k +: stls_pkg::STAT_W] = stls_pkg::STAT_W'(cnt_next[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < stls_pkg::NUM_STATS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            for (int k = 0; k < stls_pkg::NUM_STATS; k++)
            begin
                cnt_reg[k] <= ev.file_end ? '0 : cnt_next[k];
            end
        end
    end

endmodule

/* hw/rtl/source_text_line_statistics.sv */
// ----------------------------------------------------------------------------
// source_text_line_statistics
// Line, word, comment and declaration statistics over a source file stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one file byte per transaction in s_axis_tdata;
//   s_axis_tuser high marks the byte as present, so a bare transaction with
//   tuser low and tlast high just closes the file. s_axis_tlast ends the file:
//   the byte (if any) is processed first, a pending unterminated line is
//   counted, then one transaction with the twelve 32-bit totals goes out on
//   m_axis_tdata and all counters and line state return to zero.
//   Transactions without tlast produce no output.
// Throughput:
//   One transaction per cycle while no end-of-file transaction waits for the
//   output register (see Stall). Input transactions land in an input register;
//   from it the line scanner and counter bank update their state and the totals
//   go into the output register. The rate is set by the loop through the line
//   state and counter registers.
// Reset: asynchronous, active low; clears all counters, line and comment
//   state and the valid flags of both holding registers.
// Stall: while m_axis_tready is low a waiting result holds; byte-only
//   transactions keep flowing, and only the next end-of-file transaction
//   waits in the input register, which then drops s_axis_tready.
// ----------------------------------------------------------------------------
module source_text_line_statistics #(
    parameter int unsigned COUNT_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
    input  logic         s_axis_tuser,   // [0] byte_present
    input  logic         s_axis_tlast,   // end_of_file
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] lines_total, [63:32] lines_blank, [95:64] lines_comment,
    // [127:96] lines_code, [159:128] words_total, [191:160] chars_total,
    // [223:192] includes_found, [255:224] classes_found,
    // [287:256] structs_found, [319:288] enums_found,
    // [351:320] functions_estimated, [383:352] longest_line_length
    output logic [383:0] m_axis_tdata
);

    localparam int unsigned OUT_W = stls_pkg::NUM_STATS * stls_pkg::STAT_W;

    // input holding register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_present_reg;
    logic             in_eof_reg;

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic                  out_free;
    logic                  advance;
    stls_pkg::line_event_t ev;
    logic [OUT_W-1:0]      totals;

    // A byte-only transaction never needs the output side; an end-of-file
    // one needs the output register empty or draining this cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_eof_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser;
            in_eof_reg     <= s_axis_tlast;
        end
    end

    stls_line_scan u_line_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .byte_value   (in_byte_reg),
        .byte_present (in_present_reg),
        .end_of_file  (in_eof_reg),
        .ev           (ev)
    );

    stls_stat_bank #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stat_bank
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ev     (ev),
        .totals (totals)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_eof_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_eof_reg)
        begin
            out_data_reg <= totals;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* dv/source_text_line_statistics_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_line_statistics_tb
// Self-checking bench for the source text line statistics block. A short
// table of hand-picked bytes covers the edge cases. Random files built from
// C-like fragments, with some noise, run under four idle/stall mixes. Every
// statistics transaction is checked field by field against an in-bench
// line classifier, or against fixed totals for two table rows.
// ----------------------------------------------------------------------------
module source_text_line_statistics_tb;

    // Counter width of the default build
    localparam int unsigned CNT_W        = 32;
    localparam int unsigned TOT_W        = stls_pkg::NUM_STATS * stls_pkg::STAT_W;
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned N_FRAG       = 28;

    // How a directed row gets its expectation
    typedef enum logic [1:0] {
        BY_MODEL,       // from the classifier below
        ALL_ZERO,       // empty file
        ONE_CHAR_LINE   // single byte, then end of file
    } expect_kind_t;

    typedef struct packed {
        logic [7:0]   value;
        logic         present;
        logic         eof;
        expect_kind_t kind;
    } stim_row_t;

    // One unterminated line of one ordinary byte: lines, code, words, chars
    // and longest line are all 1, highest field first
    localparam logic [TOT_W-1:0] ONE_CHAR_TOTALS = {
        32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [7:0]        s_tdata = 8'd0;
    logic              s_tuser = 1'b0;
    logic              s_tlast = 1'b0;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic              m_tready = 1'b0;
    logic [TOT_W-1:0]  m_axis_tdata;

    // Expected statistics transactions, oldest first
    logic [TOT_W-1:0]  expected_totals [$];
    byte unsigned      file_bytes [$];

    int unsigned       src_idle_pct = 0;
    int unsigned       snk_stall_pct = 0;
    int unsigned       items_fed = 0;
    int unsigned       results_seen = 0;
    int unsigned       files_sent = 0;
    int unsigned       fail_count = 0;
    int unsigned       quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Line classifier state
    // ------------------------------------------------------------------------
    logic                        blk_open;   // inside a /* ... */ block
    logic                        in_token;   // inside a run of non-whitespace
    logic                        line_busy;  // current line holds at least one byte
    logic                        saw_ink;    // current line holds non-whitespace
    byte unsigned                lead [$];   // first bytes of the trimmed line
    logic [47:0]                 recent;     // last six bytes, newest lowest
    logic [stls_pkg::FLAG_W-1:0] seen;
    logic [stls_pkg::LEN_W-1:0]  line_len;
    logic [CNT_W-1:0]            tally [stls_pkg::NUM_STATS];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    source_text_line_statistics #(
        .COUNT_BITS    (CNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),      // [7:0] byte_value
        .s_axis_tuser  (s_tuser),      // [0] byte_present
        .s_axis_tlast  (s_tlast),      // end_of_file
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)  // twelve 32-bit totals, lines_total lowest
    );

    function automatic bit is_blank(input logic [7:0] b);
        return b == stls_pkg::CH_SPACE || b == stls_pkg::CH_TAB || b == stls_pkg::CH_VT ||
               b == stls_pkg::CH_FF || b == stls_pkg::CH_CR;
    endfunction

    // Trimmed line starts with s
    function automatic bit lead_is(input string s);
        if (lead.size() < s.len())
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (lead[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void bump(input stls_pkg::stat_idx_t k);
        if (tally[k] != {CNT_W{1'b1}})
            tally[k] = tally[k] + 1'b1;
    endfunction

    function automatic void clear_line();
        in_token  = 1'b0;
        line_busy = 1'b0;
        saw_ink   = 1'b0;
        lead.delete();
        recent    = '0;
        seen      = '0;
        line_len  = '0;
    endfunction

    function automatic void clear_file();
        clear_line();
        blk_open = 1'b0;
        for (int k = 0; k < stls_pkg::NUM_STATS; k++)
            tally[k] = '0;
    endfunction

    // Classify the finished line and update the line counters
    function automatic void close_line();
        logic [stls_pkg::LEN_W-1:0] len_cap;
        bit                         is_cmt;
        is_cmt = 1'b0;
        bump(stls_pkg::C_LINES);
        len_cap = (line_len > stls_pkg::LEN_W'({CNT_W{1'b1}})) ?
                  stls_pkg::LEN_W'({CNT_W{1'b1}}) : line_len;
        if (len_cap > stls_pkg::LEN_W'(tally[stls_pkg::C_LONGEST]))
            tally[stls_pkg::C_LONGEST] = CNT_W'(len_cap);
        if (!saw_ink) begin
            bump(stls_pkg::C_BLANK);
        end
        else begin
            if (blk_open) begin
                is_cmt = 1'b1;
                if (seen[stls_pkg::F_ENDC])
                    blk_open = 1'b0;
            end
            else if (lead_is("//")) begin
                is_cmt = 1'b1;
            end
            else if (lead_is("/*")) begin
                is_cmt = 1'b1;
                if (!seen[stls_pkg::F_ENDC])
                    blk_open = 1'b1;
            end
            if (is_cmt) begin
                bump(stls_pkg::C_COMMENT);
            end
            else begin
                bump(stls_pkg::C_CODE);
                if (lead_is("#include"))
                    bump(stls_pkg::C_INCL);
                if (seen[stls_pkg::F_CLASS])
                    bump(stls_pkg::C_CLASS);
                if (seen[stls_pkg::F_STRUCT])
                    bump(stls_pkg::C_STRUCT);
                if (seen[stls_pkg::F_ENUM])
                    bump(stls_pkg::C_ENUM);
                // function guess: ( ) { present, not a control statement
                if (seen[stls_pkg::F_OPEN] && seen[stls_pkg::F_CLOSE] &&
                    seen[stls_pkg::F_BRACE]
                    && !lead_is("if") && !lead_is("for") && !lead_is("while")
                    && !lead_is("switch") && !lead_is("catch"))
                    bump(stls_pkg::C_FUNC);
            end
        end
        clear_line();
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic [55:0] w;
        if (b == stls_pkg::CH_NL) begin
            close_line();
            return;
        end
        line_busy = 1'b1;
        if (line_len != '1)
            line_len = line_len + 1'b1;
        bump(stls_pkg::C_CHARS);
        if (is_blank(b)) begin
            in_token = 1'b0;
        end
        else begin
            if (!in_token)
                bump(stls_pkg::C_WORDS);
            in_token = 1'b1;
            saw_ink  = 1'b1;
        end
        if (saw_ink && lead.size() < stls_pkg::PREFIX_MAX)
            lead.push_back(b);
        w = {recent, b};
        if (b == stls_pkg::CH_OPEN)
            seen[stls_pkg::F_OPEN] = 1'b1;
        if (b == stls_pkg::CH_CLOSE)
            seen[stls_pkg::F_CLOSE] = 1'b1;
        if (b == stls_pkg::CH_BRACE)
            seen[stls_pkg::F_BRACE] = 1'b1;
        if (w[15:0] == stls_pkg::T_ENDC)
            seen[stls_pkg::F_ENDC] = 1'b1;
        if (w[47:0] == stls_pkg::T_CLASS)
            seen[stls_pkg::F_CLASS] = 1'b1;
        if (w[55:0] == stls_pkg::T_STRUCT)
            seen[stls_pkg::F_STRUCT] = 1'b1;
        if (w[39:0] == stls_pkg::T_ENUM)
            seen[stls_pkg::F_ENUM] = 1'b1;
        recent = w[47:0];
    endfunction

    // Apply one input transaction; returns 1 with the totals at end of file
    function automatic bit file_stats_step(input logic [7:0] b, input logic present,
                                           input logic eof, output logic [TOT_W-1:0] totals);
        totals = '0;
        if (present)
            scan_byte(b);
        if (!eof)
            return 1'b0;
        if (line_busy)
            close_line();
        for (int k = 0; k < stls_pkg::NUM_STATS; k++)
            totals[stls_pkg::STAT_W*k +: stls_pkg::STAT_W] = stls_pkg::STAT_W'(tally[k]);
        clear_file();
        return 1'b1;
    endfunction

    function automatic string stat_name(input stls_pkg::stat_idx_t k);
        case (k)
            stls_pkg::C_LINES:   return "lines_total";
            stls_pkg::C_BLANK:   return "lines_blank";
            stls_pkg::C_COMMENT: return "lines_comment";
            stls_pkg::C_CODE:    return "lines_code";
            stls_pkg::C_WORDS:   return "words_total";
            stls_pkg::C_CHARS:   return "chars_total";
            stls_pkg::C_INCL:    return "includes_found";
            stls_pkg::C_CLASS:   return "classes_found";
            stls_pkg::C_STRUCT:  return "structs_found";
            stls_pkg::C_ENUM:    return "enums_found";
            stls_pkg::C_FUNC:    return "functions_estimated";
            default:             return "longest_line_length";
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: edge bytes, whitespace kinds, block comment entry and
    // exit, bare items, end of file with and without a pending line.
    // ------------------------------------------------------------------------
    localparam int unsigned DIR_ROWS = 24;

    function automatic stim_row_t directed_row(input int k);
        case (k)
            0:  return '{8'hFF, 1'b0, 1'b1, ALL_ZERO};       // empty file, byte ignored
            1:  return '{8'hFF, 1'b1, 1'b1, ONE_CHAR_LINE};  // byte rides with the end
            2:  return '{8'hA5, 1'b0, 1'b0, BY_MODEL};       // bare item, no effect
            3:  return '{8'h00, 1'b1, 1'b0, BY_MODEL};       // NUL is an ordinary byte
            4:  return '{stls_pkg::CH_TAB, 1'b1, 1'b0, BY_MODEL};
            5:  return '{stls_pkg::CH_NL, 1'b1, 1'b0, BY_MODEL};
            6:  return '{stls_pkg::CH_SPACE, 1'b1, 1'b0, BY_MODEL};
            7:  return '{stls_pkg::CH_VT, 1'b1, 1'b0, BY_MODEL};
            8:  return '{stls_pkg::CH_FF, 1'b1, 1'b0, BY_MODEL};
            9:  return '{stls_pkg::CH_CR, 1'b1, 1'b0, BY_MODEL};
            10: return '{stls_pkg::CH_NL, 1'b1, 1'b0, BY_MODEL};  // whitespace-only line
            11: return '{"/", 1'b1, 1'b0, BY_MODEL};
            12: return '{"*", 1'b1, 1'b0, BY_MODEL};
            13: return '{stls_pkg::CH_NL, 1'b1, 1'b0, BY_MODEL};  // opens a block comment
            14: return '{"x", 1'b1, 1'b0, BY_MODEL};
            15: return '{"*", 1'b1, 1'b0, BY_MODEL};
            16: return '{"/", 1'b1, 1'b0, BY_MODEL};
            17: return '{stls_pkg::CH_NL, 1'b1, 1'b0, BY_MODEL};  // closes it
            18: return '{"/", 1'b1, 1'b0, BY_MODEL};
            19: return '{"/", 1'b1, 1'b0, BY_MODEL};
            20: return '{8'h00, 1'b0, 1'b1, BY_MODEL};       // pending line counted at end
            21: return '{"/", 1'b1, 1'b0, BY_MODEL};
            22: return '{"/", 1'b1, 1'b0, BY_MODEL};
            default: return '{stls_pkg::CH_NL, 1'b1, 1'b1, BY_MODEL};  // newline with the end
        endcase
    endfunction

    // C-like pieces the random lines are assembled from
    function automatic string fragment(input int k);
        case (k)
            0:  return "#include <stdio.h>";
            1:  return "#include";
            2:  return "class ";
            3:  return "struct ";
            4:  return "enum ";
            5:  return "if (";
            6:  return "for (";
            7:  return "while (";
            8:  return "switch (";
            9:  return "catch (";
            10: return "int f(";
            11: return ")";
            12: return "{";
            13: return "}";
            14: return "//";
            15: return "/*";
            16: return "*/";
            17: return "/*/";
            18: return "x = 1;";
            19: return "clas";
            20: return "enum";
            21: return "return";
            22: return "void g(int a) {";
            23: return "ifx(a){";
            24: return "forward(){";
            25: return "*";
            26: return "/";
            default: return "#includes";
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(7))
            0:       return stls_pkg::CH_TAB;
            1:       return stls_pkg::CH_VT;
            2:       return stls_pkg::CH_FF;
            3:       return stls_pkg::CH_CR;
            default: return stls_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    // One line without its newline: indent, then a few fragments
    function automatic void add_line();
        int n;
        n = $urandom_range(0, 4);
        repeat ($urandom_range(0, 2))
            file_bytes.push_back(pick_space());
        repeat (n) begin
            if ($urandom_range(15) == 0)
                file_bytes.push_back(8'($urandom));   // stray byte
            else
                add_text(fragment($urandom_range(0, N_FRAG - 1)));
            if ($urandom_range(2) == 0)
                file_bytes.push_back(pick_space());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one input transaction, with random idle cycles ahead of it.
    // The classifier runs at the edge that accepts the transaction.
    // ------------------------------------------------------------------------
    task automatic feed(input logic [7:0] b, input logic present, input logic eof,
                        input expect_kind_t kind);
        logic [TOT_W-1:0] totals;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= eof;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (file_stats_step(b, present, eof, totals)) begin
            case (kind)
                ALL_ZERO:      totals = '0;
                ONE_CHAR_LINE: totals = ONE_CHAR_TOTALS;
                default:       ;
            endcase
            expected_totals.push_back(totals);
            files_sent++;
        end
        if (present || eof)
            items_fed++;
    endtask

    // Hold the input idle until every expected result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_totals.size() != 0);
    endtask

    // A random file: mostly well-formed lines, sometimes raw noise
    task automatic send_file();
        int n_lines;
        file_bytes.delete();
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 40))
                file_bytes.push_back(8'($urandom));
        end
        else begin
            n_lines = $urandom_range(0, 8);
            for (int i = 0; i < n_lines; i++) begin
                add_line();
                // the last line is left unterminated half the time
                if (i < n_lines - 1 || $urandom_range(1))
                    file_bytes.push_back(stls_pkg::CH_NL);
            end
        end
        while (file_bytes.size() > 1) begin
            if ($urandom_range(29) == 0)
                feed(8'($urandom), 1'b0, 1'b0, BY_MODEL);
            feed(file_bytes.pop_front(), 1'b1, 1'b0, BY_MODEL);
        end
        if (file_bytes.size() == 1 && $urandom_range(1)) begin
            feed(file_bytes.pop_front(), 1'b1, 1'b1, BY_MODEL);
        end
        else begin
            if (file_bytes.size() == 1)
                feed(file_bytes.pop_front(), 1'b1, 1'b0, BY_MODEL);
            feed(8'($urandom), 1'b0, 1'b1, BY_MODEL);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each accepted result, then pick next cycle's tready
    // ------------------------------------------------------------------------
    task automatic check_totals(input logic [TOT_W-1:0] got);
        logic [TOT_W-1:0] want;
        if (expected_totals.size() == 0) begin
            $error("statistics transaction with nothing expected: %h", got);
            fail_count++;
            return;
        end
        want = expected_totals.pop_front();
        for (int k = 0; k < stls_pkg::NUM_STATS; k++) begin
            if (got[stls_pkg::STAT_W*k +: stls_pkg::STAT_W] !==
                want[stls_pkg::STAT_W*k +: stls_pkg::STAT_W]) begin
                $error("%s: expected %0d, got %0d", stat_name(stls_pkg::stat_idx_t'(k)),
                       want[stls_pkg::STAT_W*k +: stls_pkg::STAT_W],
                       got[stls_pkg::STAT_W*k +: stls_pkg::STAT_W]);
                fail_count++;
            end
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_tready)
            check_totals(m_axis_tdata);
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: too long without a transaction on either side
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, expected_totals.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t   row;
        int unsigned mark;

        clear_file();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            row = directed_row(k);
            feed(row.value, row.present, row.eof, row.kind);
        end
        drain_results();

        // Random files: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 30 : 0;
            snk_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 30 : 0;
            mark = items_fed;
            while (items_fed - mark < RANDOM_ITEMS / 4)
                send_file();
            drain_results();
        end

        snk_stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("Covered %0d input transactions over %0d files (table, random)",
                 items_fed, files_sent);
        $display("Checked %0d statistics transactions across four idle/stall mixes",
                 results_seen);
        if (fail_count == 0 && expected_totals.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
